### rtl/sgcr_pkg.sv
// sgcr_pkg: shared types, constants and font table of the scaled glyph column renderer
// no dependencies
package sgcr_pkg;

    localparam int PAGE_COUNT = 8;
    localparam int CHAR_PITCH = 6;
    localparam int GLYPH_W    = 5;
    localparam int JOB_DEPTH  = 2;

    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd100;
    localparam logic [2:0] PAGE_MASK  = 3'(PAGE_COUNT - 1);

    typedef enum logic {
        CMD_WRITE_CHAR = 1'b0,
        CMD_SET_CURSOR = 1'b1
    } t_command;

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
        logic [1:0] scale_code;
        logic [7:0] new_column;
        logic [7:0] new_page;
    } t_in_item;

    typedef struct packed {
        logic [31:0] column_pixels;
        logic [6:0]  column_address;
        logic [2:0]  start_page;
        logic [2:0]  page_count;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [39:0] glyph;
        logic [1:0]  scale_code;
        logic [4:0]  total;
        logic [6:0]  column;
        logic [2:0]  page;
    } t_job;

    // five glyph column bytes, column 0 in the low byte, bit 0 is the top row
    function automatic logic [39:0] glyph_lookup(input logic [6:0] idx);
        logic [39:0] g;
        case (idx)
            7'd0:  g = 40'h0000000000;
            7'd1:  g = 40'h00002f0000;
            7'd2:  g = 40'h0007000700;
            7'd3:  g = 40'h147f147f14;
            7'd4:  g = 40'h122a7f2a24;
            7'd5:  g = 40'h2313086462;
            7'd6:  g = 40'h5022554936;
            7'd7:  g = 40'h0000030500;
            7'd8:  g = 40'h0041221c00;
            7'd9:  g = 40'h001c224100;
            7'd10: g = 40'h14083e0814;
            7'd11: g = 40'h08083e0808;
            7'd12: g = 40'h0060a00000;
            7'd13: g = 40'h0808080808;
            7'd14: g = 40'h0000606000;
            7'd15: g = 40'h0204081020;
            7'd16: g = 40'h3e4549513e;
            7'd17: g = 40'h00407f4200;
            7'd18: g = 40'h4649516142;
            7'd19: g = 40'h314b454121;
            7'd20: g = 40'h107f121418;
            7'd21: g = 40'h3945454527;
            7'd22: g = 40'h3049494a3c;
            7'd23: g = 40'h0305097101;
            7'd24: g = 40'h3649494936;
            7'd25: g = 40'h1e29494906;
            7'd26: g = 40'h0000363600;
            7'd27: g = 40'h0000365600;
            7'd28: g = 40'h0041221408;
            7'd29: g = 40'h1414141414;
            7'd30: g = 40'h0814224100;
            7'd31: g = 40'h0609510102;
            7'd32: g = 40'h3e51594932;
            7'd33: g = 40'h7c1211127c;
            7'd34: g = 40'h364949497f;
            7'd35: g = 40'h224141413e;
            7'd36: g = 40'h1c2241417f;
            7'd37: g = 40'h414949497f;
            7'd38: g = 40'h010909097f;
            7'd39: g = 40'h7a4949413e;
            7'd40: g = 40'h7f0808087f;
            7'd41: g = 40'h00417f4100;
            7'd42: g = 40'h013f414020;
            7'd43: g = 40'h412214087f;
            7'd44: g = 40'h404040407f;
            7'd45: g = 40'h7f020c027f;
            7'd46: g = 40'h7f1008047f;
            7'd47: g = 40'h3e4141413e;
            7'd48: g = 40'h060909097f;
            7'd49: g = 40'h5e2151413e;
            7'd50: g = 40'h462919097f;
            7'd51: g = 40'h3149494946;
            7'd52: g = 40'h01017f0101;
            7'd53: g = 40'h3f4040403f;
            7'd54: g = 40'h1f2040201f;
            7'd55: g = 40'h3f4038403f;
            7'd56: g = 40'h6314081463;
            7'd57: g = 40'h0708700807;
            7'd58: g = 40'h4345495161;
            7'd59: g = 40'h0041417f00;
            7'd60: g = 40'h2010080402;
            7'd61: g = 40'h007f414100;
            7'd62: g = 40'h0402010204;
            7'd63: g = 40'h4040404040;
            7'd64: g = 40'h3838383838;
            7'd65: g = 40'hffffffffff;
            7'd66: g = 40'hffffffffff;
            7'd67: g = 40'hffffffffff;
            7'd68: g = 40'hffffffffff;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

    // repeat each glyph bit vertically by the scale
    function automatic logic [31:0] stretch_column(input logic [7:0] bits,
                                                   input logic [1:0] scale_code);
        logic [31:0] acc;
        acc = '0;
        case (scale_code)
            2'd0: acc[7:0] = bits;
            2'd1: for (int r = 0; r < 8; r++) acc[2*r +: 2] = {2{bits[r]}};
            2'd2: for (int r = 0; r < 8; r++) acc[3*r +: 3] = {3{bits[r]}};
            2'd3: for (int r = 0; r < 8; r++) acc[4*r +: 4] = {4{bits[r]}};
            default: acc = '0;
        endcase
        return acc;
    endfunction

endpackage

### rtl/scaled_glyph_column_renderer.sv
// scaled_glyph_column_renderer: top level of the scaled 5x8 character generator
// depends on sgcr_pkg, sgcr_front, sgcr_job_fifo, sgcr_back
//
// A write item renders one character at scale 1 to 4 as 6*scale column transfers
// (6, 12, 18 or 24), one per clock while results are popped, each carrying the
// stretched column bytes, its column address, start page and page count; the
// column walker in the back end sets that figure of one column per cycle. A
// set-cursor item only moves the cursor and yields nothing. Glyph lookup and cursor
// update happen at input acceptance, and a two-entry job queue lets new items
// be accepted while earlier characters are still being emitted.
module scaled_glyph_column_renderer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  sgcr_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output sgcr_pkg::t_out_item o_item
);

    logic           job_push, job_pop, job_full, job_empty;
    sgcr_pkg::t_job front_job, queue_job;

    sgcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .i_job_full (job_full),
        .o_full     (full),
        .o_job_push (job_push),
        .o_job      (front_job)
    );

    sgcr_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .i_pop   (job_pop),
        .o_full  (job_full),
        .o_empty (job_empty),
        .o_job   (queue_job)
    );

    sgcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (queue_job),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_item)
    );

endmodule

### rtl/sgcr_front.sv
// sgcr_front: accepts items, keeps the cursor, looks up glyphs and issues render jobs
// depends on sgcr_pkg
module sgcr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sgcr_pkg::t_in_item i_item,
    input  logic              i_job_full,
    output logic              o_full,
    output logic              o_job_push,
    output sgcr_pkg::t_job    o_job
);

    logic [6:0] r_cursor_column, n_cursor_column;
    logic [2:0] r_cursor_page, n_cursor_page;
    logic       accept;
    logic [6:0] glyph_idx;
    logic [4:0] total;

    assign o_full = i_job_full;
    assign accept = i_push && !i_job_full;

    always_comb begin
        if (i_item.char_code < sgcr_pkg::FIRST_CODE || i_item.char_code > sgcr_pkg::LAST_CODE) begin
            glyph_idx = 7'd0;
        end else begin
            glyph_idx = 7'(i_item.char_code - sgcr_pkg::FIRST_CODE);
        end
        total = 5'(sgcr_pkg::CHAR_PITCH * (int'(i_item.scale_code) + 1));
    end

    always_comb begin
        o_job.glyph      = sgcr_pkg::glyph_lookup(glyph_idx);
        o_job.scale_code = i_item.scale_code;
        o_job.total      = total;
        o_job.column     = r_cursor_column;
        o_job.page       = r_cursor_page;
        o_job_push       = accept && (i_item.command == sgcr_pkg::CMD_WRITE_CHAR);
        n_cursor_column  = r_cursor_column;
        n_cursor_page    = r_cursor_page;
        if (accept) begin
            if (i_item.command == sgcr_pkg::CMD_SET_CURSOR) begin
                n_cursor_column = i_item.new_column[6:0];
                n_cursor_page   = i_item.new_page[2:0] & sgcr_pkg::PAGE_MASK;
            end else begin
                n_cursor_column = r_cursor_column + 7'(total);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_column <= '0;
            r_cursor_page   <= '0;
        end else begin
            r_cursor_column <= n_cursor_column;
            r_cursor_page   <= n_cursor_page;
        end
    end

endmodule

### rtl/sgcr_job_fifo.sv
// sgcr_job_fifo: short queue of render jobs between front and back
// depends on sgcr_pkg
module sgcr_job_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sgcr_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output sgcr_pkg::t_job o_job
);

    localparam int PTR_W = (sgcr_pkg::JOB_DEPTH > 1) ? $clog2(sgcr_pkg::JOB_DEPTH) : 1;
    localparam int CNT_W = $clog2(sgcr_pkg::JOB_DEPTH + 1);

    sgcr_pkg::t_job    r_mem [sgcr_pkg::JOB_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(sgcr_pkg::JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(sgcr_pkg::JOB_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(sgcr_pkg::JOB_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/sgcr_back.sv
// sgcr_back: walks a render job column by column into the result register
// depends on sgcr_pkg
module sgcr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_empty,
    input  sgcr_pkg::t_job     i_job,
    output logic               o_job_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output sgcr_pkg::t_out_item o_item
);

    sgcr_pkg::t_job      r_job;
    logic                r_busy;
    logic [4:0]          r_idx;
    logic [2:0]          r_gcol;
    logic [1:0]          r_rep;
    logic [6:0]          r_col;
    sgcr_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic                advance, emit, slice_last, load;
    logic [7:0]          col_byte;
    sgcr_pkg::t_out_item slice;

    assign advance    = !r_out_valid || i_pop;
    assign emit       = r_busy && advance;
    assign slice_last = (r_idx == r_job.total - 5'd1);
    assign load       = !i_job_empty && (!r_busy || (emit && slice_last));
    assign o_job_pop  = load;
    assign o_empty    = !r_out_valid;
    assign o_item     = r_out;

    always_comb begin
        case (r_gcol)
            3'd0: col_byte = r_job.glyph[7:0];
            3'd1: col_byte = r_job.glyph[15:8];
            3'd2: col_byte = r_job.glyph[23:16];
            3'd3: col_byte = r_job.glyph[31:24];
            3'd4: col_byte = r_job.glyph[39:32];
            default: col_byte = 8'd0;
        endcase
        slice.column_pixels  = sgcr_pkg::stretch_column(col_byte, r_job.scale_code);
        slice.column_address = r_col;
        slice.start_page     = r_job.page;
        slice.page_count     = {1'b0, r_job.scale_code} + 3'd1;
        slice.last           = slice_last;
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= slice;
        end
        if (load) begin
            r_job <= i_job;
            r_col <= i_job.column;
        end else if (emit) begin
            r_col <= r_col + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_gcol      <= '0;
            r_rep       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_gcol <= '0;
                r_rep  <= '0;
            end else if (emit) begin
                if (slice_last) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + 5'd1;
                if (r_rep == r_job.scale_code) begin
                    r_rep  <= '0;
                    r_gcol <= r_gcol + 3'd1;
                end else begin
                    r_rep <= r_rep + 2'd1;
                end
            end
        end
    end

endmodule
